// File: rtl/lwd_pkg.sv
// Shared types and constants for the link loss watchdog.
// Depends on nothing; every other file in rtl imports it.
package lwd_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROBES_PER_BATCH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOSS_THRESHOLD   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAIL_LIMIT       = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] PROBES_PER_BATCH_RST = 8'd1;
    localparam logic [CFG_DATA_W-1:0] LOSS_THRESHOLD_RST   = 8'd1;
    localparam logic [CFG_DATA_W-1:0] FAIL_LIMIT_RST       = 8'd5;

    // Streak counter width default
    localparam int COUNTER_BITS_DEF = 8;

    // Result field widths
    localparam int STREAK_OUT_W = 8;
    localparam int EVENT_W      = 2;

    // Alarm event codes
    localparam logic [EVENT_W-1:0] EVT_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_FAIL    = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_RESTORE = 2'd2;

    // Alarm state, one-hot
    typedef enum logic [2:0] {
        ALARM_GOOD    = 3'b001,
        ALARM_BAD     = 3'b010,
        ALARM_UNKNOWN = 3'b100
    } alarm_state_t;

    // Batch outcome handed from the batch counter to the alarm logic
    typedef struct packed {
        logic ended;
        logic failed;
    } batch_result_t;

endpackage

// File: rtl/lwd_batch.sv
// Batch counter: tracks probe position and losses in the current batch
// and decides batch end and batch failure. Depends on lwd_pkg.
module lwd_batch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          probe_lost,
    input  logic [lwd_pkg::CFG_DATA_W-1:0] probes_per_batch,
    input  logic [lwd_pkg::CFG_DATA_W-1:0] loss_threshold,
    output lwd_pkg::batch_result_t         result
);
    import lwd_pkg::*;

    logic [CFG_DATA_W-1:0] probe_index_reg;
    logic [CFG_DATA_W-1:0] probe_index_next;
    logic [CFG_DATA_W-1:0] batch_losses_reg;
    logic [CFG_DATA_W-1:0] batch_losses_next;
    logic [CFG_DATA_W-1:0] size;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] losses_upd;
    logic [CFG_DATA_W:0]   index_inc;

    // Clamp batch size and threshold
    assign size = (probes_per_batch == '0) ? CFG_DATA_W'(1) : probes_per_batch;
    assign thr  = (loss_threshold > size) ? size : loss_threshold;

    // Count losses, saturating
    assign losses_upd = (probe_lost && (batch_losses_reg != '1))
                        ? batch_losses_reg + CFG_DATA_W'(1) : batch_losses_reg;

    // Detect batch end and failure
    assign index_inc     = {1'b0, probe_index_reg} + (CFG_DATA_W+1)'(1);
    assign result.ended  = (index_inc >= {1'b0, size});
    assign result.failed = result.ended && (losses_upd >= thr);

    // Advance position, restart at batch end
    always_comb
    begin
        if (result.ended)
        begin
            probe_index_next  = '0;
            batch_losses_next = '0;
        end
        else
        begin
            probe_index_next  = index_inc[CFG_DATA_W-1:0];
            batch_losses_next = losses_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_index_reg  <= '0;
            batch_losses_reg <= '0;
        end
        else if (advance)
        begin
            probe_index_reg  <= probe_index_next;
            batch_losses_reg <= batch_losses_next;
        end
    end

endmodule

// File: rtl/lwd_alarm.sv
// Alarm logic: failed-batch streak and the good/bad alarm state with
// its failure and restore events. Depends on lwd_pkg.
module lwd_alarm #(
    parameter int COUNTER_BITS = lwd_pkg::COUNTER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  lwd_pkg::batch_result_t          result,
    input  logic [lwd_pkg::CFG_DATA_W-1:0]  fail_limit,
    output logic [lwd_pkg::EVENT_W-1:0]     alarm_event,
    output logic [lwd_pkg::STREAK_OUT_W-1:0] fail_streak
);
    import lwd_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > CFG_DATA_W) ? COUNTER_BITS : CFG_DATA_W;

    logic [COUNTER_BITS-1:0] streak_reg;
    logic [COUNTER_BITS-1:0] streak_next;
    alarm_state_t            alarm_state_reg;
    alarm_state_t            alarm_state_next;
    logic [CMP_W-1:0]        streak_ext;

    // Extend streak on failure, clear on a good batch
    always_comb
    begin
        streak_next = streak_reg;
        if (result.ended)
        begin
            if (!result.failed)
                streak_next = '0;
            else if (streak_reg != '1)
                streak_next = streak_reg + COUNTER_BITS'(1);
        end
    end

    assign streak_ext = CMP_W'(streak_next);

    // Announce failure or restore once per transition
    always_comb
    begin
        alarm_event      = EVT_NONE;
        alarm_state_next = alarm_state_reg;
        if (result.ended)
        begin
            if ((streak_ext > CMP_W'(fail_limit)) && (alarm_state_reg != ALARM_BAD))
            begin
                alarm_event      = EVT_FAIL;
                alarm_state_next = ALARM_BAD;
            end
            if ((streak_next == '0) && (alarm_state_reg != ALARM_GOOD))
            begin
                alarm_event      = EVT_RESTORE;
                alarm_state_next = ALARM_GOOD;
            end
        end
    end

    // Show the streak saturated to the field width
    assign fail_streak = (streak_ext > CMP_W'({STREAK_OUT_W{1'b1}}))
                         ? {STREAK_OUT_W{1'b1}} : streak_ext[STREAK_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streak_reg      <= '0;
            alarm_state_reg <= ALARM_UNKNOWN;
        end
        else if (advance)
        begin
            streak_reg      <= streak_next;
            alarm_state_reg <= alarm_state_next;
        end
    end

endmodule

// File: rtl/link_loss_watchdog_unit.sv
// Link loss watchdog top level: config registers, input register,
// result register. Depends on lwd_pkg, lwd_batch and lwd_alarm.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | probe_lost
//   out     | out_valid/out_ready| alarm_event, batch_end, batch_failed, fail_streak
//   cfg     | cfg_we             | cfg_addr, cfg_data
//
// An item waits in the input register until the result register is free
// or being taken, and then moves to the result register, which presents
// its result. One item per cycle is sustained while results are taken;
// batch and alarm state update as an item leaves the input register.
// Reset clears control state and sets the alarm state to unknown. A
// stalled result holds the input register, and the input side stalls only
// when both registers are full and the result is not being taken.
module link_loss_watchdog_unit #(
    parameter int COUNTER_BITS = lwd_pkg::COUNTER_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             probe_lost,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lwd_pkg::EVENT_W-1:0]      alarm_event,
    output logic                             batch_end,
    output logic                             batch_failed,
    output logic [lwd_pkg::STREAK_OUT_W-1:0] fail_streak,
    input  logic                             cfg_we,
    input  logic [lwd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lwd_pkg::*;

    logic [CFG_DATA_W-1:0]   probes_per_batch_reg;
    logic [CFG_DATA_W-1:0]   loss_threshold_reg;
    logic [CFG_DATA_W-1:0]   fail_limit_reg;

    logic                    in_valid_reg;
    logic                    probe_lost_reg;
    logic                    out_valid_reg;
    logic [EVENT_W-1:0]      alarm_event_reg;
    logic                    batch_end_reg;
    logic                    batch_failed_reg;
    logic [STREAK_OUT_W-1:0] fail_streak_reg;

    logic                    advance;
    batch_result_t           result;
    logic [EVENT_W-1:0]      event_next;
    logic [STREAK_OUT_W-1:0] streak_next;

    // Move an item to the result register when it is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Write config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probes_per_batch_reg <= PROBES_PER_BATCH_RST;
            loss_threshold_reg   <= LOSS_THRESHOLD_RST;
            fail_limit_reg       <= FAIL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PROBES_PER_BATCH: probes_per_batch_reg <= cfg_data;
                REG_LOSS_THRESHOLD:   loss_threshold_reg   <= cfg_data;
                REG_FAIL_LIMIT:       fail_limit_reg       <= cfg_data;
                default:              ;
            endcase
        end
    end

    lwd_batch u_batch (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .probe_lost       (probe_lost_reg),
        .probes_per_batch (probes_per_batch_reg),
        .loss_threshold   (loss_threshold_reg),
        .result           (result)
    );

    lwd_alarm #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_alarm (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .result      (result),
        .fail_limit  (fail_limit_reg),
        .alarm_event (event_next),
        .fail_streak (streak_next)
    );

    // Track valid flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            probe_lost_reg <= probe_lost;
        if (advance)
        begin
            alarm_event_reg  <= event_next;
            batch_end_reg    <= result.ended;
            batch_failed_reg <= result.failed;
            fail_streak_reg  <= streak_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign alarm_event  = alarm_event_reg;
    assign batch_end    = batch_end_reg;
    assign batch_failed = batch_failed_reg;
    assign fail_streak  = fail_streak_reg;

endmodule

// File: rtl/lwd_checker.sv
// Port-level checks for the link loss watchdog, bound to the top level.
// Depends on lwd_pkg and link_loss_watchdog_unit.
module lwd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [lwd_pkg::EVENT_W-1:0]      alarm_event,
    input logic                             batch_end,
    input logic                             batch_failed,
    input logic [lwd_pkg::STREAK_OUT_W-1:0] fail_streak
);
    import lwd_pkg::*;

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alarm_event)
            && $stable(batch_end) && $stable(batch_failed) && $stable(fail_streak))
        else $error("result changed while stalled");

    // Announce only at a batch end
    a_event_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (alarm_event != EVT_NONE) |-> batch_end)
        else $error("alarm event outside a batch end");

    // Fail only a completed batch
    a_fail_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_failed |-> batch_end)
        else $error("failed flag outside a batch end");

    // Clear the streak on a good batch, and a good batch never declares failure
    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_end && !batch_failed |-> (fail_streak == '0)
            && (alarm_event != EVT_FAIL))
        else $error("good batch left streak or declared failure");

endmodule

bind link_loss_watchdog_unit lwd_checker u_lwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .alarm_event  (alarm_event),
    .batch_end    (batch_end),
    .batch_failed (batch_failed),
    .fail_streak  (fail_streak)
);

// File: tb/testbench.sv
// Self-checking bench for link_loss_watchdog_unit: random valid/ready idling on both
// channels, register writes between phases, and a predictor checking every result.
// Depends on lwd_pkg and the link_loss_watchdog_unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lwd_pkg::*;

    localparam int STREAK_BITS = COUNTER_BITS_DEF;
    localparam logic [STREAK_BITS-1:0] STREAK_MAX = {STREAK_BITS{1'b1}};
    localparam int IDLE_PCT = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    // Register index beyond the map; writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [EVENT_W-1:0]      alarm_code;
        logic                    ended;
        logic                    failed;
        logic [STREAK_OUT_W-1:0] streak;
    } probe_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic probe_lost = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [EVENT_W-1:0] alarm_event;
    logic batch_end;
    logic batch_failed;
    logic [STREAK_OUT_W-1:0] fail_streak;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_PROBES_PER_BATCH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register shadows seen by the predictor
    logic [7:0] batch_size_cfg = PROBES_PER_BATCH_RST;
    logic [7:0] loss_thr_cfg = LOSS_THRESHOLD_RST;
    logic [7:0] fail_limit_cfg = FAIL_LIMIT_RST;

    // Predictor state
    logic [7:0] probe_count = '0;
    logic [7:0] loss_count = '0;
    logic [STREAK_BITS-1:0] streak_count = '0;
    alarm_state_t link_state = ALARM_UNKNOWN;

    logic probe_queue[$];
    probe_outcome_t expected_outcomes[$];

    logic calm = 1'b0;
    logic probe_taken = 1'b0;
    int cycle_count = 0;
    int error_count = 0;
    int result_count = 0;
    int batch_count = 0;
    int fail_count = 0;
    int restore_count = 0;
    int streak_peak = 0;

    link_loss_watchdog_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .probe_lost(probe_lost),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .alarm_event(alarm_event),
        .batch_end(batch_end),
        .batch_failed(batch_failed),
        .fail_streak(fail_streak),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance batch and alarm state by one probe outcome
    function automatic probe_outcome_t score_probe(input logic lost);
        logic [8:0] size;
        logic [8:0] thr;
        probe_outcome_t res;
        size = (batch_size_cfg == 8'd0) ? 9'd1 : {1'b0, batch_size_cfg};
        thr = ({1'b0, loss_thr_cfg} > size) ? size : {1'b0, loss_thr_cfg};
        res = '0;
        if (lost && loss_count != 8'hFF)
            loss_count = loss_count + 8'd1;
        if ({1'b0, probe_count} + 9'd1 >= size)
        begin
            res.ended = 1'b1;
            res.failed = ({1'b0, loss_count} >= thr);
            if (res.failed)
            begin
                if (streak_count != STREAK_MAX)
                    streak_count = streak_count + 1'b1;
            end
            else
                streak_count = '0;
            if (streak_count > fail_limit_cfg && link_state != ALARM_BAD)
            begin
                res.alarm_code = EVT_FAIL;
                link_state = ALARM_BAD;
            end
            if (streak_count == 0 && link_state != ALARM_GOOD)
            begin
                res.alarm_code = EVT_RESTORE;
                link_state = ALARM_GOOD;
            end
            probe_count = '0;
            loss_count = '0;
        end
        else
            probe_count = probe_count + 8'd1;
        res.streak = (streak_count > 255) ? 8'hFF : streak_count[7:0];
        return res;
    endfunction

    // Drive probe items and result backpressure on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || probe_taken)
        begin
            if (probe_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                probe_lost <= probe_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Sample both channels on the rising edge: check results, predict new items
    always @(posedge clk)
    begin
        probe_outcome_t exp_res;
        cycle_count <= cycle_count + 1;
        probe_taken = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t ns: result with none expected (event %0d end %0d fail %0d streak %0d)",
                         $time, alarm_event, batch_end, batch_failed, fail_streak);
                error_count++;
            end
            else
            begin
                exp_res = expected_outcomes.pop_front();
                result_count++;
                if (alarm_event !== exp_res.alarm_code)
                begin
                    $display("%0t ns: alarm_event expected %0d, got %0d",
                             $time, exp_res.alarm_code, alarm_event);
                    error_count++;
                end
                if (batch_end !== exp_res.ended)
                begin
                    $display("%0t ns: batch_end expected %0d, got %0d",
                             $time, exp_res.ended, batch_end);
                    error_count++;
                end
                if (batch_failed !== exp_res.failed)
                begin
                    $display("%0t ns: batch_failed expected %0d, got %0d",
                             $time, exp_res.failed, batch_failed);
                    error_count++;
                end
                if (fail_streak !== exp_res.streak)
                begin
                    $display("%0t ns: fail_streak expected %0d, got %0d",
                             $time, exp_res.streak, fail_streak);
                    error_count++;
                end
                if (exp_res.ended)
                    batch_count++;
                if (exp_res.alarm_code == EVT_FAIL)
                    fail_count++;
                if (exp_res.alarm_code == EVT_RESTORE)
                    restore_count++;
                if (exp_res.streak > streak_peak)
                    streak_peak = exp_res.streak;
            end
        end
        if (probe_taken)
            expected_outcomes.push_back(score_probe(probe_lost));
    end

    // Stop a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_outcomes.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_PROBES_PER_BATCH: batch_size_cfg = val;
            REG_LOSS_THRESHOLD:   loss_thr_cfg = val;
            REG_FAIL_LIMIT:       fail_limit_cfg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued item is accepted and every result has arrived
    task automatic wait_idle();
        while (probe_queue.size() != 0 || in_valid || expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_probes(input int count, input int loss_pct);
        for (int i = 0; i < count; i++)
            probe_queue.push_back($urandom_range(99) < loss_pct);
    endtask

    // Whole batches, each mostly lost, clean or mixed, to build and break streaks
    task automatic queue_batches(input int batches);
        int len;
        int mode;
        len = (batch_size_cfg == 8'd0) ? 1 : batch_size_cfg;
        for (int b = 0; b < batches; b++)
        begin
            mode = $urandom_range(9);
            if (mode < 4)
                queue_probes(len, 100);
            else if (mode < 7)
                queue_probes(len, 0);
            else
                queue_probes(len, 50);
        end
    endtask

    initial
    begin
        logic [CFG_ADDR_W-1:0] reg_ids[3];
        logic [7:0] vals[3];
        int first;
        int pick;
        reg_ids = '{REG_PROBES_PER_BATCH, REG_LOSS_THRESHOLD, REG_FAIL_LIMIT};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: restore from unknown, streak past the limit, restore again
        queue_probes(1, 0);
        queue_probes(7, 100);
        queue_probes(1, 0);
        wait_idle();

        // Zero batch size, zero threshold, zero limit; spare index ignored
        write_reg(REG_PROBES_PER_BATCH, 8'd0);
        write_reg(REG_LOSS_THRESHOLD, 8'd0);
        write_reg(REG_FAIL_LIMIT, 8'd0);
        write_reg(REG_SPARE, 8'hFF);
        queue_probes(2, 0);
        wait_idle();

        // Threshold above batch size clamps to the batch size
        write_reg(REG_PROBES_PER_BATCH, 8'd3);
        write_reg(REG_LOSS_THRESHOLD, 8'd200);
        write_reg(REG_FAIL_LIMIT, 8'd255);
        probe_queue.push_back(1'b1);
        probe_queue.push_back(1'b1);
        probe_queue.push_back(1'b0);
        queue_probes(3, 100);
        wait_idle();

        // Lower the batch size in the middle of a batch
        write_reg(REG_PROBES_PER_BATCH, 8'd4);
        write_reg(REG_LOSS_THRESHOLD, 8'd2);
        probe_queue.push_back(1'b1);
        probe_queue.push_back(1'b0);
        wait_idle();
        write_reg(REG_PROBES_PER_BATCH, 8'd2);
        probe_queue.push_back(1'b1);
        wait_idle();

        // Saturate the streak with no idling on either side
        write_reg(REG_PROBES_PER_BATCH, 8'd1);
        write_reg(REG_LOSS_THRESHOLD, 8'd0);
        write_reg(REG_FAIL_LIMIT, 8'd254);
        calm = 1'b1;
        queue_probes(270, 50);
        wait_idle();
        calm = 1'b0;

        // Random settings, each phase a run of batches or a partial batch of the largest size
        for (int phase = 0; phase < 9; phase++)
        begin
            pick = $urandom_range(9);
            vals[0] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 6));
            if (phase == 3)
                vals[0] = 8'd255;
            pick = $urandom_range(9);
            vals[1] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 7));
            pick = $urandom_range(9);
            vals[2] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 4));
            first = $urandom_range(2);
            for (int k = 0; k < 3; k++)
                write_reg(reg_ids[(first + k) % 3], vals[(first + k) % 3]);
            if ($urandom_range(3) == 0)
                write_reg(REG_SPARE, 8'($urandom_range(255)));
            // A full batch of the largest size is too long; leave it partial
            if (batch_size_cfg == 8'd255)
                queue_probes(40, 60);
            else
                queue_batches($urandom_range(6, 14));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results over %0d batch ends, peak streak %0d",
                 result_count, batch_count, streak_peak);
        $display("Failure announced %0d times, restore announced %0d times",
                 fail_count, restore_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: link_loss_watchdog_unit.f
rtl/lwd_pkg.sv
rtl/lwd_batch.sv
rtl/lwd_alarm.sv
rtl/link_loss_watchdog_unit.sv
rtl/lwd_checker.sv
tb/testbench.sv
